// File: rtl/core/dll_pkg.sv
`timescale 1ns / 1ps

package dll_pkg;

  // Fixed field widths of the request and result channels
  localparam int unsigned FUNC_W  = 2;
  localparam int unsigned POS_W   = 9;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned FOUND_W = 8;
  localparam int unsigned CNT_W   = 9;

  typedef enum logic [FUNC_W-1:0] {
    FN_INSERT  = 2'd0,
    FN_REM_VAL = 2'd1,
    FN_REM_POS = 2'd2,
    FN_SEARCH  = 2'd3
  } func_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_BAD_POS   = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECIDE,
    S_ALLOC,
    S_POP,
    S_HEAD1,
    S_HEAD2,
    S_WSTART,
    S_WALK,
    S_LINK1,
    S_LINK2,
    S_UNL1,
    S_UNL2,
    S_DONE
  } state_t;

  typedef enum logic [3:0] {
    DP_IDLE,
    DP_LATCH,
    DP_ALLOC,
    DP_POP,
    DP_HEAD1,
    DP_HEAD2,
    DP_WALK_START,
    DP_WALK,
    DP_LINK1,
    DP_LINK2,
    DP_UNL1,
    DP_UNL2,
    DP_RESP
  } dp_op_t;

  typedef struct packed {
    dp_op_t  op;
    status_t status;
  } cmd_t;

  typedef struct packed {
    func_t func;
    logic  pos_gt;
    logic  pos_ge;
    logic  pos_zero;
    logic  full;
    logic  walk_hit;
    logic  walk_miss;
    logic  out_busy;
  } sts_t;

endpackage

// File: rtl/core/dll_req_if.sv
`timescale 1ns / 1ps

interface dll_req_if;
  logic                                valid;
  logic                                ready;
  logic        [dll_pkg::FUNC_W-1:0]   func;
  logic        [dll_pkg::POS_W-1:0]    position;
  logic signed [dll_pkg::DATA_W-1:0]   value;

  modport source (output valid, func, position, value, input ready);
  modport sink   (input valid, func, position, value, output ready);
endinterface

// File: rtl/core/dll_rsp_if.sv
`timescale 1ns / 1ps

interface dll_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [dll_pkg::STAT_W-1:0]     status;
  logic [dll_pkg::FOUND_W-1:0]    found_position;
  logic [dll_pkg::CNT_W-1:0]      item_count;
  logic                           is_empty;

  modport source (output valid, status, found_position, item_count, is_empty, input ready);
  modport sink   (input valid, status, found_position, item_count, is_empty, output ready);
endinterface

// File: rtl/core/doubly_linked_list_engine_unit.sv
`timescale 1ns / 1ps

// Doubly linked list of CAPACITY signed values in on-chip node memories with a
// free list. One request (insert at position, remove by value, remove at
// position, search) is handled at a time and gives one result. A request
// that needs a node walks the list from the head, and the walk reads the node
// memories once per node before the result is offered. The result sits in an
// output register, so the next request is taken while the previous result
// waits. Reset needs no clearing pass.
module doubly_linked_list_engine_unit #(
  parameter int unsigned CAPACITY    = 256,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input logic   clk,
  input logic   rst_n,
  dll_req_if.sink   in_ch,
  dll_rsp_if.source out_ch
);
  import dll_pkg::*;

  cmd_t cmd;
  sts_t sts;

  dll_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  dll_datapath #(
    .CAPACITY    (CAPACITY),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_func            (in_ch.func),
    .in_position        (in_ch.position),
    .in_value           (in_ch.value),
    .out_ready          (out_ch.ready),
    .out_valid          (out_ch.valid),
    .out_status         (out_ch.status),
    .out_found_position (out_ch.found_position),
    .out_item_count     (out_ch.item_count),
    .out_is_empty       (out_ch.is_empty)
  );

`ifndef NO_ASSERTIONS
  // One request in flight at a time
  a_single_request: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("request taken while another is in flight");

  // A walk keeps going until it hits or runs off the list
  a_walk_continues: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == DP_WALK && !sts.walk_hit && !sts.walk_miss |=> cmd.op == DP_WALK)
    else $error("walk abandoned early");

  // Empty flag agrees with the count
  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_ch.is_empty == (out_ch.item_count == '0))
    else $error("empty flag disagrees with item count");
`endif

endmodule

// File: rtl/core/dll_ctrl.sv
`timescale 1ns / 1ps

module dll_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  dll_pkg::sts_t sts,
  output dll_pkg::cmd_t cmd
);
  import dll_pkg::*;

  state_t  state_r, state_nxt;
  status_t status_r, status_nxt;

  // State and status registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      status_r <= ST_OK;
    end else begin
      state_r  <= state_nxt;
      status_r <= status_nxt;
    end
  end

  // Sequence one request through the datapath
  always_comb begin
    state_nxt  = state_r;
    status_nxt = status_r;
    cmd.op     = DP_IDLE;
    cmd.status = status_r;
    in_ready   = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op     = DP_LATCH;
          status_nxt = ST_OK;
          state_nxt  = S_DECIDE;
        end
      end
      S_DECIDE: begin
        case (sts.func)
          FN_INSERT: begin
            if (sts.pos_gt) begin
              status_nxt = ST_BAD_POS;
              state_nxt  = S_DONE;
            end else if (sts.full) begin
              status_nxt = ST_FULL;
              state_nxt  = S_DONE;
            end else begin
              state_nxt = S_ALLOC;
            end
          end
          FN_REM_POS: begin
            if (sts.pos_ge) begin
              status_nxt = ST_BAD_POS;
              state_nxt  = S_DONE;
            end else begin
              state_nxt = S_WSTART;
            end
          end
          default: state_nxt = S_WSTART;
        endcase
      end
      S_ALLOC: begin
        cmd.op    = DP_ALLOC;
        state_nxt = S_POP;
      end
      S_POP: begin
        cmd.op    = DP_POP;
        state_nxt = sts.pos_zero ? S_HEAD1 : S_WSTART;
      end
      S_HEAD1: begin
        cmd.op    = DP_HEAD1;
        state_nxt = S_HEAD2;
      end
      S_HEAD2: begin
        cmd.op    = DP_HEAD2;
        state_nxt = S_DONE;
      end
      S_WSTART: begin
        cmd.op    = DP_WALK_START;
        state_nxt = S_WALK;
      end
      S_WALK: begin
        cmd.op = DP_WALK;
        if (sts.walk_miss) begin
          status_nxt = (sts.func == FN_REM_VAL || sts.func == FN_SEARCH) ?
                       ST_NOT_FOUND : ST_BAD_POS;
          state_nxt  = S_DONE;
        end else if (sts.walk_hit) begin
          case (sts.func)
            FN_INSERT: state_nxt = S_LINK1;
            FN_SEARCH: state_nxt = S_DONE;
            default:   state_nxt = S_UNL1;
          endcase
        end
      end
      S_LINK1: begin
        cmd.op    = DP_LINK1;
        state_nxt = S_LINK2;
      end
      S_LINK2: begin
        cmd.op    = DP_LINK2;
        state_nxt = S_DONE;
      end
      S_UNL1: begin
        cmd.op    = DP_UNL1;
        state_nxt = S_UNL2;
      end
      S_UNL2: begin
        cmd.op    = DP_UNL2;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!sts.out_busy) begin
          cmd.op    = DP_RESP;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

// File: rtl/core/dll_datapath.sv
`timescale 1ns / 1ps

module dll_datapath #(
  parameter int unsigned CAPACITY    = 256,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  dll_pkg::cmd_t                       cmd,
  output dll_pkg::sts_t                       sts,
  input  logic        [dll_pkg::FUNC_W-1:0]   in_func,
  input  logic        [dll_pkg::POS_W-1:0]    in_position,
  input  logic signed [dll_pkg::DATA_W-1:0]   in_value,
  input  logic                                out_ready,
  output logic                                out_valid,
  output logic        [dll_pkg::STAT_W-1:0]   out_status,
  output logic        [dll_pkg::FOUND_W-1:0]  out_found_position,
  output logic        [dll_pkg::CNT_W-1:0]    out_item_count,
  output logic                                out_is_empty
);
  import dll_pkg::*;

  localparam int unsigned IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] NIL = CW'(CAPACITY);

  // Node memories
  logic [VALUE_WIDTH-1:0] val_mem  [CAPACITY];
  logic [CW-1:0]          next_mem [CAPACITY];
  logic [CW-1:0]          prev_mem [CAPACITY];
  logic [VALUE_WIDTH-1:0] val_q;
  logic [CW-1:0]          next_q, prev_q;

  // Request and list registers
  func_t                  func_r;
  logic [POS_W-1:0]       pos_r, rem_r;
  logic [VALUE_WIDTH-1:0] val_r;
  logic [CW-1:0]          head_r, free_r, fill_r, count_r;
  logic [CW-1:0]          node_r, n_r, nx_r, p_r, idx_r, rd_addr_r;
  logic                   nfresh_r;
  logic                   out_valid_r, out_empty_r;
  status_t                out_status_r;
  logic [FOUND_W-1:0]     out_found_r;
  logic [CNT_W-1:0]       out_count_r;

  logic [CW-1:0]          rd_addr, qnext;
  logic                   val_mode, x_nil, walk_hit, walk_miss, step;
  logic                   val_we, next_we, prev_we;
  logic [CW-1:0]          val_wa, next_wa, prev_wa, next_wd, prev_wd;

  // Entries at or above the fill mark were never written; their next link reads as the following index
  assign qnext    = nfresh_r ? rd_addr_r + CW'(1) : next_q;
  assign val_mode = (func_r == FN_REM_VAL) || (func_r == FN_SEARCH);
  assign x_nil    = node_r >= NIL;
  assign walk_miss = x_nil || (val_mode && idx_r >= NIL);
  assign walk_hit  = !walk_miss && (val_mode ? (val_q == val_r) : (rem_r == '0));
  assign step      = (cmd.op == DP_WALK) && !walk_hit && !walk_miss;

  // Select the read address
  always_comb begin
    case (cmd.op)
      DP_ALLOC:      rd_addr = free_r;
      DP_WALK_START: rd_addr = head_r;
      default:       rd_addr = qnext;
    endcase
  end

  // Write ports, one write per memory per cycle
  always_comb begin
    val_we  = 1'b0;
    next_we = 1'b0;
    prev_we = 1'b0;
    val_wa  = free_r;
    next_wa = n_r;
    prev_wa = n_r;
    next_wd = head_r;
    prev_wd = NIL;
    case (cmd.op)
      DP_ALLOC: val_we = 1'b1;
      DP_HEAD1: begin
        next_we = 1'b1;
        prev_we = 1'b1;
      end
      DP_HEAD2: begin
        prev_we = head_r < NIL;
        prev_wa = head_r;
        prev_wd = n_r;
      end
      DP_LINK1: begin
        next_we = 1'b1;
        next_wd = nx_r;
        prev_we = 1'b1;
        prev_wd = node_r;
      end
      DP_LINK2: begin
        next_we = 1'b1;
        next_wa = node_r;
        next_wd = n_r;
        prev_we = nx_r < NIL;
        prev_wa = nx_r;
        prev_wd = n_r;
      end
      DP_UNL1: begin
        prev_we = nx_r < NIL;
        prev_wa = nx_r;
        prev_wd = p_r;
        next_we = p_r < NIL;
        next_wa = p_r;
        next_wd = nx_r;
      end
      DP_UNL2: begin
        next_we = 1'b1;
        next_wa = node_r;
        next_wd = free_r;
      end
      default: ;
    endcase
  end

  // Memory access with registered read data
  always_ff @(posedge clk) begin
    if (val_we)  val_mem[val_wa[IW-1:0]]   <= val_r;
    if (next_we) next_mem[next_wa[IW-1:0]] <= next_wd;
    if (prev_we) prev_mem[prev_wa[IW-1:0]] <= prev_wd;
    val_q     <= val_mem[rd_addr[IW-1:0]];
    next_q    <= next_mem[rd_addr[IW-1:0]];
    prev_q    <= prev_mem[rd_addr[IW-1:0]];
    rd_addr_r <= rd_addr;
    nfresh_r  <= rd_addr >= fill_r;
  end

  // List control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= NIL;
      free_r      <= '0;
      fill_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.op == DP_RESP) out_valid_r <= 1'b1;
      else if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      case (cmd.op)
        DP_ALLOC: if (free_r == fill_r) fill_r <= fill_r + CW'(1);
        DP_POP:   free_r <= qnext;
        DP_HEAD2: begin
          head_r  <= n_r;
          count_r <= count_r + CW'(1);
        end
        DP_LINK2: count_r <= count_r + CW'(1);
        DP_UNL1:  if (p_r >= NIL) head_r <= nx_r;
        DP_UNL2: begin
          free_r  <= node_r;
          count_r <= count_r - CW'(1);
        end
        default: ;
      endcase
    end
  end

  // Request, walk and result payload
  always_ff @(posedge clk) begin
    case (cmd.op)
      DP_LATCH: begin
        func_r <= func_t'(in_func);
        pos_r  <= in_position;
        val_r  <= VALUE_WIDTH'(in_value);
      end
      DP_ALLOC: n_r <= free_r;
      DP_WALK_START: begin
        node_r <= head_r;
        idx_r  <= '0;
        rem_r  <= (func_r == FN_INSERT) ? pos_r - POS_W'(1) : pos_r;
      end
      DP_WALK: begin
        nx_r <= qnext;
        p_r  <= prev_q;
        if (step) begin
          node_r <= qnext;
          idx_r  <= idx_r + CW'(1);
          rem_r  <= rem_r - POS_W'(1);
        end
      end
      DP_RESP: begin
        out_status_r <= cmd.status;
        out_found_r  <= (func_r == FN_SEARCH && cmd.status == ST_OK) ?
                        FOUND_W'(idx_r) : '0;
        out_count_r  <= CNT_W'(count_r);
        out_empty_r  <= count_r == '0;
      end
      default: ;
    endcase
  end

  // Status towards the controller
  always_comb begin
    sts.func      = func_r;
    sts.pos_gt    = 32'(pos_r) > 32'(count_r);
    sts.pos_ge    = 32'(pos_r) >= 32'(count_r);
    sts.pos_zero  = pos_r == '0;
    sts.full      = (count_r >= NIL) || (free_r >= NIL);
    sts.walk_hit  = walk_hit;
    sts.walk_miss = walk_miss;
    sts.out_busy  = out_valid_r && !out_ready;
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_found_position = out_found_r;
  assign out_item_count     = out_count_r;
  assign out_is_empty       = out_empty_r;

endmodule

// File: dv/dll_tb_pkg.sv
`timescale 1ns / 1ps

package dll_tb_pkg;
  import dll_pkg::*;

  localparam int unsigned LIST_CAP = 256;

  // One predicted result
  typedef struct packed {
    status_t          status;
    logic [7:0]       found_pos;
    logic [8:0]       count;
    logic             empty;
  } list_result_t;

  // Shadow of the list plus the queue of results still owed by the block
  class list_shadow;
    logic signed [31:0] vals[$];
    list_result_t       owed[$];
    int                 mismatches;
    int                 checked;

    function int find_pos(logic signed [31:0] v);
      foreach (vals[i]) if (vals[i] == v) return i;
      return -1;
    endfunction

    // Apply an accepted request and note the result it owes
    function void note_request(func_t f, logic [8:0] pos, logic signed [31:0] v);
      list_result_t r;
      int           idx;
      r = '0;
      r.status = ST_OK;
      case (f)
        FN_INSERT: begin
          if (pos > vals.size()) r.status = ST_BAD_POS;
          else if (vals.size() >= LIST_CAP) r.status = ST_FULL;
          else vals.insert(pos, v);
        end
        FN_REM_VAL: begin
          idx = find_pos(v);
          if (idx < 0) r.status = ST_NOT_FOUND;
          else vals.delete(idx);
        end
        FN_REM_POS: begin
          if (pos >= vals.size()) r.status = ST_BAD_POS;
          else vals.delete(pos);
        end
        default: begin
          idx = find_pos(v);
          if (idx < 0) r.status = ST_NOT_FOUND;
          else r.found_pos = idx[7:0];
        end
      endcase
      r.count = 9'(vals.size());
      r.empty = (vals.size() == 0);
      owed.push_back(r);
    endfunction

    // Compare one result with the oldest owed one
    function void check_result(list_result_t got);
      list_result_t want;
      checked++;
      if (owed.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("tb: result with nothing owed: %p", got);
        return;
      end
      want = owed.pop_front();
      if (got.status !== want.status || got.found_pos !== want.found_pos ||
          got.count !== want.count || got.empty !== want.empty) begin
        mismatches++;
        if (mismatches <= 10)
          $display("tb: mismatch st %0d/%0d pos %0d/%0d cnt %0d/%0d empty %0d/%0d",
                   want.status, got.status, want.found_pos, got.found_pos,
                   want.count, got.count, want.empty, got.empty);
      end
    endfunction
  endclass
endpackage

// File: dv/tb.sv
`timescale 1ns / 1ps

module tb;
  import dll_pkg::*;
  import dll_tb_pkg::*;

  localparam int WATCHDOG = 20000;

  logic clk;
  logic rst_n;
  dll_req_if in_ch ();
  dll_rsp_if out_ch ();

  doubly_linked_list_engine_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  list_shadow shadow;
  bit         quiet_tail;
  bit         hold_off;
  int         sent;
  int         idle_cycles;
  int         fills;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    shadow = new();
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.func = '0;
    in_ch.position = '0;
    in_ch.value = '0;
    out_ch.ready = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Collect results; random stall bursts, plus one long hold-off on request
  initial begin
    list_result_t got;
    int           gap;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_off) begin
        out_ch.ready <= 1'b0;
        repeat (600) @(posedge clk);
        hold_off = 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
        out_ch.ready <= 1'b0;
        gap = $urandom_range(1, 13);
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      if (out_ch.valid && out_ch.ready) begin
        got.status    = status_t'(out_ch.status);
        got.found_pos = out_ch.found_position;
        got.count     = out_ch.item_count;
        got.empty     = out_ch.is_empty;
        shadow.check_result(got);
      end
    end
  end

  // Offer one request and hold it until accepted
  task automatic send_request(func_t f, logic [8:0] pos, logic signed [31:0] v);
    int gap;
    if (!quiet_tail && $urandom_range(0, 7) == 0) begin
      in_ch.valid <= 1'b0;
      gap = $urandom_range(1, 13);
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.func <= f;
    in_ch.position <= pos;
    in_ch.value <= v;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    shadow.note_request(f, pos, v);
    sent++;
  endtask

  task automatic drain_wait();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (shadow.owed.size() != 0) @(posedge clk);
  endtask

  // Values drawn mostly from a small pool so searches and removals hit
  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return 32'sh8000_0000;
      2: return 32'sh7fff_ffff;
      default: return $urandom_range(0, 15);
    endcase
  endfunction

  function automatic logic [8:0] pick_pos(int sz, bit for_insert);
    case ($urandom_range(0, 9))
      0: return 9'($urandom_range(0, 511));
      1: return for_insert ? 9'(sz) : 9'(sz - 1);
      2: return 9'd256;
      default: return (sz == 0) ? 9'd0 :
                      9'($urandom_range(0, for_insert ? sz : sz - 1));
    endcase
  endfunction

  initial begin
    func_t f;
    int    sz;
    @(posedge clk iff rst_n);
    // Directed: empty-list cases, ends, and positions out of range
    send_request(FN_REM_POS, 9'd0, 0);
    send_request(FN_SEARCH, 9'd0, 5);
    send_request(FN_REM_VAL, 9'd0, 5);
    send_request(FN_INSERT, 9'd1, 1);
    send_request(FN_INSERT, 9'd0, 32'sh8000_0000);
    send_request(FN_INSERT, 9'd1, 32'sh7fff_ffff);
    send_request(FN_INSERT, 9'd1, -1);
    send_request(FN_INSERT, 9'd3, 0);
    send_request(FN_INSERT, 9'h1ff, 0);
    send_request(FN_SEARCH, 9'h1ff, 32'sh7fff_ffff);
    send_request(FN_SEARCH, 9'd0, 0);
    send_request(FN_REM_POS, 9'd4, 0);
    send_request(FN_REM_POS, 9'd3, 0);
    send_request(FN_REM_VAL, 9'd0, -1);
    send_request(FN_REM_POS, 9'd0, 0);
    send_request(FN_REM_VAL, 9'd0, 32'sh7fff_ffff);
    send_request(FN_SEARCH, 9'd0, 32'sh7fff_ffff);
    // Fill to capacity while the receiver holds off, then probe full list
    hold_off = 1'b1;
    for (int i = 0; i < 256; i++) send_request(FN_INSERT, 9'(i), i);
    send_request(FN_INSERT, 9'd0, 7);
    send_request(FN_INSERT, 9'd256, 7);
    send_request(FN_INSERT, 9'd257, 7);
    send_request(FN_SEARCH, 9'd0, 255);
    send_request(FN_REM_POS, 9'd255, 0);
    fills++;
    drain_wait();
    // Random mix; pause for a full drain partway through
    for (int i = 0; i < 470; i++) begin
      if (i == 200) drain_wait();
      if (i == 400) quiet_tail = 1'b1;
      sz = shadow.vals.size();
      case ($urandom_range(0, 9))
        0, 1, 2, 3: f = FN_INSERT;
        4, 5: f = FN_REM_VAL;
        6, 7: f = FN_REM_POS;
        default: f = FN_SEARCH;
      endcase
      if (sz > 60 && f == FN_INSERT && $urandom_range(0, 1)) f = FN_REM_POS;
      send_request(f, pick_pos(sz, f == FN_INSERT), pick_value());
    end
    drain_wait();
    repeat (300) @(posedge clk);
    $display("tb: %0d requests sent, %0d results checked, list filled %0d time(s)",
             sent, shadow.checked, fills);
    $display("tb: covered all operations, bad positions, misses and a full list");
    if (shadow.mismatches == 0 && shadow.owed.size() == 0) $display("tb: PASS");
    else $display("tb: FAIL");
    $finish;
  end

  // Watchdog: count cycles with no request or result moving
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG) begin
      $display("tb: FAIL");
      $finish;
    end
  end
endmodule
